// ----- hdl/fm_pkg.sv -----
// Package for the single-precision multiplier: default widths and cell count.
// Depends on nothing; float32_multiplier refers to it for its parameter defaults.
package fm_pkg;
   localparam int EXP_WIDTH_DEF  = 8;
   localparam int FRAC_WIDTH_DEF = 23;
   // Number of partial-product cells in the multiplier chain.
   localparam int CELL_COUNT_DEF = 4;
endpackage

// ----- hdl/fm_if.sv -----
// Valid/ready channel interface used by the multiplier's request and response sides.
// Depends on nothing but its width parameter.
interface fm_if #(
   parameter int WIDTH = 32
) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/fm_cell.sv -----
// One cell of the significand multiplier chain: adds one slice of partial products.
// Depends on no other file; all widths come from parameters.
module fm_cell #(
   parameter int MW    = 24,
   parameter int SLICE = 6,
   parameter int INDEX = 0,
   parameter int EW    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              valid_i,
   input  logic [MW-1:0]     ma_i,
   input  logic [MW-1:0]     mb_i,
   input  logic [2*MW-1:0]   acc_i,
   input  logic              sign_i,
   input  logic signed [EW+2:0] exp_i,
   output logic              valid_o,
   output logic [MW-1:0]     ma_o,
   output logic [MW-1:0]     mb_o,
   output logic [2*MW-1:0]   acc_o,
   output logic              sign_o,
   output logic signed [EW+2:0] exp_o
);
   localparam int LO = INDEX * SLICE;
   localparam int HI = ((LO + SLICE) < MW) ? (LO + SLICE) : MW;
   localparam int W  = HI - LO;

   logic [W-1:0]       b_slice;
   logic [2*MW-1:0]    part;
   logic               valid_ff;
   logic [MW-1:0]      ma_ff, mb_ff;
   logic [2*MW-1:0]    acc_ff, acc_in;
   logic               sign_ff;
   logic signed [EW+2:0] exp_ff;

   always_comb begin
      b_slice = mb_i[HI-1:LO];
      part    = (2*MW)'(ma_i * b_slice) << LO;
      acc_in  = acc_i + part;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ma_ff   <= ma_i;
         mb_ff   <= mb_i;
         acc_ff  <= acc_in;
         sign_ff <= sign_i;
         exp_ff  <= exp_i;
      end
   end

   assign valid_o = valid_ff;
   assign ma_o    = ma_ff;
   assign mb_o    = mb_ff;
   assign acc_o   = acc_ff;
   assign sign_o  = sign_ff;
   assign exp_o   = exp_ff;
endmodule

// ----- hdl/fm_round.sv -----
// Normalize, round to nearest even and clamp the exponent of the finished product.
// Depends on no other file; widths come from parameters.
module fm_round #(
   parameter int EW = 8,
   parameter int FW = 23
) (
   input  logic [2*FW+1:0]       prod_i,
   input  logic                  sign_i,
   input  logic signed [EW+2:0]  exp_i,
   output logic [EW+FW:0]        word_o
);
   localparam int MW = FW + 1;
   localparam logic signed [EW+2:0] EXP_MAX = (EW+3)'((1 << EW) - 1);

   logic                  top;
   logic [MW:0]           q;
   logic                  guard, sticky;
   logic signed [EW+2:0]  e;
   logic [MW:0]           qr;
   logic [EW-1:0]         ef;
   logic [FW-1:0]         frac;

   always_comb begin
      top = prod_i[2*FW+1];
      e   = exp_i;
      if (top) begin
         q      = {1'b0, prod_i[2*FW+1:FW+1]};
         guard  = prod_i[FW];
         sticky = |prod_i[FW-1:0];
         e      = e + (EW+3)'(1);
      end else begin
         q      = {1'b0, prod_i[2*FW:FW]};
         guard  = prod_i[FW-1];
         sticky = |prod_i[FW-2:0];
      end
      qr = q;
      if (guard && (sticky || q[0])) begin
         qr = q + (MW+1)'(1);
      end
      if (qr[MW]) begin
         qr = qr >> 1;
         e  = e + (EW+3)'(1);
      end
      frac = qr[FW-1:0];
      if (e > EXP_MAX) begin
         ef = EXP_MAX[EW-1:0];
      end else if (e < 0) begin
         ef = '0;
      end else begin
         ef = e[EW-1:0];
      end
      word_o = {sign_i, ef, frac};
   end
endmodule

// ----- hdl/float32_multiplier.sv -----
// Single-precision multiplier: one operand pair per transaction in, one product out.
// Depends on fm_pkg, fm_if, fm_cell and fm_round.
//
// The block accepts a new transaction every clock cycle unless the chain is stalled. The
// significand product runs through a chain of CELL_COUNT cells, each adding the partial
// products of one slice of operand_b. The last cell feeds the rounding logic, whose result
// is captured in one output register. The first cell registers a transaction at its
// accepting edge; it then moves through each later cell and into the output register.
// The chain only stalls when the output register is full and not being taken. Inputs
// are always treated as normalized with an implied one; subnormals, infinities and
// NaN receive no special handling. The exponent saturates at all ones and clamps to
// zero on underflow, while the rounded fraction is kept.
module float32_multiplier #(
   parameter int EXP_WIDTH  = fm_pkg::EXP_WIDTH_DEF,
   parameter int FRAC_WIDTH = fm_pkg::FRAC_WIDTH_DEF,
   parameter int CELL_COUNT = fm_pkg::CELL_COUNT_DEF
) (
   input logic clock,
   input logic reset,
   fm_if.sink   req_operand_a,
   fm_if.sink   req_operand_b,
   fm_if.source rsp_product
);
   localparam int TW    = 1 + EXP_WIDTH + FRAC_WIDTH;
   localparam int MW    = FRAC_WIDTH + 1;
   localparam int SLICE = (MW + CELL_COUNT - 1) / CELL_COUNT;
   localparam int EB    = (1 << (EXP_WIDTH - 1)) - 1;

   logic                        adv;
   logic                        accept;
   logic [CELL_COUNT:0]         valid_c;
   logic [MW-1:0]               ma_c   [CELL_COUNT+1];
   logic [MW-1:0]               mb_c   [CELL_COUNT+1];
   logic [2*MW-1:0]             acc_c  [CELL_COUNT+1];
   logic                        sign_c [CELL_COUNT+1];
   logic signed [EXP_WIDTH+2:0] exp_c  [CELL_COUNT+1];
   logic                        out_valid_ff;
   logic [TW-1:0]               out_data_ff;
   logic [TW-1:0]               word;

   // The chain advances whenever the output register is free or being drained.
   assign adv    = !out_valid_ff || rsp_product.ready;
   assign accept = req_operand_a.valid && req_operand_b.valid && adv;
   assign req_operand_a.ready = adv && req_operand_b.valid;
   assign req_operand_b.ready = adv && req_operand_a.valid;

   // Head of the chain: unpack the operands and form the biased exponent sum.
   always_comb begin
      valid_c[0] = accept;
      ma_c[0]    = {1'b1, req_operand_a.data[FRAC_WIDTH-1:0]};
      mb_c[0]    = {1'b1, req_operand_b.data[FRAC_WIDTH-1:0]};
      acc_c[0]   = '0;
      sign_c[0]  = req_operand_a.data[TW-1] ^ req_operand_b.data[TW-1];
      exp_c[0]   = $signed((EXP_WIDTH+3)'(req_operand_a.data[TW-2:FRAC_WIDTH]))
                 + $signed((EXP_WIDTH+3)'(req_operand_b.data[TW-2:FRAC_WIDTH]))
                 - $signed((EXP_WIDTH+3)'(EB));
   end

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      fm_cell #(
         .MW(MW), .SLICE(SLICE), .INDEX(i), .EW(EXP_WIDTH)
      ) u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .valid_i(valid_c[i]), .ma_i(ma_c[i]), .mb_i(mb_c[i]), .acc_i(acc_c[i]),
         .sign_i(sign_c[i]), .exp_i(exp_c[i]),
         .valid_o(valid_c[i+1]), .ma_o(ma_c[i+1]), .mb_o(mb_c[i+1]),
         .acc_o(acc_c[i+1]), .sign_o(sign_c[i+1]), .exp_o(exp_c[i+1])
      );
   end

   fm_round #(
      .EW(EXP_WIDTH), .FW(FRAC_WIDTH)
   ) u_round (
      .prod_i(acc_c[CELL_COUNT]),
      .sign_i(sign_c[CELL_COUNT]),
      .exp_i(exp_c[CELL_COUNT]),
      .word_o(word)
   );

   // Output register: holds a finished transaction until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= valid_c[CELL_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= word;
      end
   end

   assign rsp_product.valid = out_valid_ff;
   assign rsp_product.data  = out_data_ff;

`ifndef SYNTHESIS
   // A result that is not taken must stay in place.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_product.ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("pending product changed");
   // No transaction enters while the chain is stalled.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |-> !accept)
      else $error("transaction accepted during stall");
   // A transaction leaving the last cell lands in the output register.
   a_land: assert property (@(posedge clock) disable iff (reset)
      adv && valid_c[CELL_COUNT] |=> out_valid_ff)
      else $error("finished transaction lost");
`endif
endmodule
